>>> rtl/core/tlfs_pkg.sv
package tlfs_pkg;

	localparam int IdW   = 16;
	localparam int PrioW = 8;
	localparam int ServW = 16;
	localparam int TimeW = 32;
	localparam int QuantW = 8;
	localparam logic [QuantW-1:0] QuantumReset = 8'd20;

	typedef enum logic {
		KIND_ARRIVAL = 1'b0,
		KIND_TICK    = 1'b1
	} kind_t;

	typedef enum logic {
		ST_DONE   = 1'b0,
		ST_REJECT = 1'b1
	} status_t;

	typedef enum logic {
		SRC_RR   = 1'b0,
		SRC_FIFO = 1'b1
	} src_t;

	typedef struct packed {
		logic [IdW-1:0]   id;
		logic [PrioW-1:0] prio;
		logic [ServW-1:0] serv;
		logic [ServW-1:0] rem;
		logic [TimeW-1:0] arrival;
	} job_t;

	typedef struct packed {
		logic [IdW-1:0]   job_id;
		logic [PrioW-1:0] job_priority;
		logic [ServW-1:0] service_time;
		kind_t            kind;
	} in_item_t;

	typedef struct packed {
		status_t          status;
		logic [IdW-1:0]   done_id;
		logic [PrioW-1:0] done_priority;
		logic [ServW-1:0] done_service;
		logic [TimeW-1:0] turnaround;
		src_t             finished_in;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_result;
	} sts_t;

endpackage

>>> rtl/core/tlfs_in_if.sv
interface tlfs_in_if;
	import tlfs_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/tlfs_out_if.sv
interface tlfs_out_if;
	import tlfs_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/tlfs_cfg_if.sv
interface tlfs_cfg_if;
	import tlfs_pkg::*;
	logic              valid;
	logic              ready;
	logic [QuantW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/tlfs_ctrl.sv
module tlfs_ctrl
	import tlfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.has_result) begin
					state_d = S_OUT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d = S_EXEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> rtl/core/tlfs_dp.sv
module tlfs_dp
	import tlfs_pkg::*;
#(
	parameter int QueueDepth = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  in_item_t          in_data,
	input  logic              cfg_we,
	input  logic [QuantW-1:0] cfg_data,
	output out_item_t         out_data
);

	localparam int AW = $clog2(QueueDepth);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] Depth = CW'(QueueDepth);

	job_t rr_mem [QueueDepth];
	job_t ff_mem [QueueDepth];

	logic [QuantW-1:0] quantum_q;
	logic [TimeW-1:0]  time_q;
	logic [AW-1:0]     rr_head_q, rr_tail_q, ff_head_q, ff_tail_q;
	logic [CW-1:0]     rr_cnt_q, ff_cnt_q, inflight_q;
	job_t              run_q;
	logic              run_valid_q;
	src_t              run_src_q;
	logic [QuantW-1:0] slice_q;
	in_item_t          item_q;
	job_t              rr_rd_q, ff_rd_q;
	out_item_t         out_q;

	// heads read in the load cycle, registered
	always_ff @(posedge clk) begin
		rr_rd_q <= rr_mem[rr_head_q];
		ff_rd_q <= ff_mem[ff_head_q];
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	logic        arrive, tick, reject, start_rr, start_ff, have, fin, demote;
	job_t        cur;
	src_t        cur_src;
	logic [QuantW-1:0] slice_n;
	logic [TimeW-1:0]  time_n;
	logic [ServW-1:0]  rem_n;

	always_comb begin
		arrive = cmd.exec && (item_q.kind == KIND_ARRIVAL);
		tick = cmd.exec && (item_q.kind == KIND_TICK);
		reject = (item_q.service_time == '0) || (inflight_q >= Depth);
		time_n = time_q + 1'b1;
		start_rr = !run_valid_q && (rr_cnt_q != '0);
		start_ff = !run_valid_q && (rr_cnt_q == '0) && (ff_cnt_q != '0);
		have = run_valid_q || start_rr || start_ff;
		cur = run_q;
		cur_src = run_src_q;
		slice_n = slice_q;
		if (start_rr) begin
			cur = rr_rd_q;
			cur_src = SRC_RR;
			slice_n = '0;
		end else if (start_ff) begin
			cur = ff_rd_q;
			cur_src = SRC_FIFO;
			slice_n = '0;
		end
		if (slice_n != '1) begin
			slice_n = slice_n + 1'b1;
		end
		rem_n = (cur.rem != '0) ? cur.rem - 1'b1 : '0;
		fin = tick && have && (rem_n == '0);
		demote = tick && have && !fin && (
			((cur_src == SRC_RR) && (slice_n >= quantum_q)) ||
			((cur_src == SRC_FIFO) && ((rr_cnt_q - CW'(start_rr)) != '0)));
		sts.has_result = (arrive && reject) || fin;
	end

	always_ff @(posedge clk) begin
		if (arrive && !reject) begin
			rr_mem[rr_tail_q] <= '{id: item_q.job_id, prio: item_q.job_priority,
				serv: item_q.service_time, rem: item_q.service_time, arrival: time_q};
		end
		if (demote) begin
			ff_mem[ff_tail_q] <= '{id: cur.id, prio: cur.prio, serv: cur.serv,
				rem: rem_n, arrival: cur.arrival};
		end
		if (arrive && reject) begin
			out_q <= '{status: ST_REJECT, done_id: item_q.job_id,
				done_priority: item_q.job_priority, done_service: item_q.service_time,
				turnaround: '0, finished_in: SRC_RR};
		end else if (fin) begin
			out_q <= '{status: ST_DONE, done_id: cur.id, done_priority: cur.prio,
				done_service: cur.serv, turnaround: time_n - cur.arrival,
				finished_in: cur_src};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QuantumReset;
			time_q <= '0;
			rr_head_q <= '0;
			rr_tail_q <= '0;
			rr_cnt_q <= '0;
			ff_head_q <= '0;
			ff_tail_q <= '0;
			ff_cnt_q <= '0;
			inflight_q <= '0;
			run_q <= '0;
			run_valid_q <= 1'b0;
			run_src_q <= SRC_RR;
			slice_q <= '0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_data;
			end
			if (arrive && !reject) begin
				rr_tail_q <= (rr_tail_q == AW'(QueueDepth - 1)) ? '0 : rr_tail_q + 1'b1;
				rr_cnt_q <= rr_cnt_q + 1'b1;
				inflight_q <= inflight_q + 1'b1;
			end
			if (tick) begin
				time_q <= time_n;
				if (start_rr) begin
					rr_head_q <= (rr_head_q == AW'(QueueDepth - 1)) ? '0 : rr_head_q + 1'b1;
					rr_cnt_q <= rr_cnt_q - 1'b1;
				end
				if (have) begin
					run_q <= '{id: cur.id, prio: cur.prio, serv: cur.serv,
						rem: rem_n, arrival: cur.arrival};
					run_src_q <= cur_src;
					slice_q <= slice_n;
					run_valid_q <= !(fin || demote);
				end
				if (fin && inflight_q != '0) begin
					inflight_q <= inflight_q - 1'b1;
				end
				if (demote) begin
					ff_tail_q <= (ff_tail_q == AW'(QueueDepth - 1)) ? '0 : ff_tail_q + 1'b1;
				end
				ff_cnt_q <= ff_cnt_q + CW'(demote) - CW'(start_ff);
				if (start_ff) begin
					ff_head_q <= (ff_head_q == AW'(QueueDepth - 1)) ? '0 : ff_head_q + 1'b1;
				end
			end
		end
	end

	assign out_data = out_q;

endmodule

>>> rtl/core/two_level_feedback_scheduler.sv
// channel   dir  content
// in        in   kind, job_id, job_priority, service_time
// out       out  status, done_id, done_priority, done_service, turnaround, finished_in
// cfg       in   quantum
// per item: transfer and queue head read, then schedule and write-back; no new item is taken meanwhile
// a result holds in the output register; the next item transfers with its take
// arst_n clears pointers, counts and running job; queue memories are not cleared
// cfg always ready; a new quantum applies from the next schedule step
module two_level_feedback_scheduler
	import tlfs_pkg::*;
#(
	parameter int QueueDepth = 128
) (
	input logic        clk,
	input logic        arst_n,
	tlfs_in_if.sink    in,
	tlfs_out_if.source out,
	tlfs_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	tlfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tlfs_dp #(.QueueDepth(QueueDepth)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in.data),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.out_data (out.data)
	);

endmodule

>>> rtl/core/tlfs_checker.sv
module tlfs_checker
	import tlfs_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");

	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_REJECT |->
			out_data.turnaround == '0 && out_data.finished_in == SRC_RR)
		else $error("bad reject result");

endmodule

bind two_level_feedback_scheduler tlfs_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in.valid),
	.in_ready  (in.ready),
	.out_valid (out.valid),
	.out_ready (out.ready),
	.out_data  (out.data)
);

>>> dv/tlfs_tb_pkg.sv
package tlfs_tb_pkg;
	import tlfs_pkg::*;

	localparam int Depth = 128;

	class sched_scoreboard;
		bit [7:0]  quantum;
		bit [31:0] now;
		job_t      rr_q[$];
		job_t      fifo_q[$];
		job_t      cur;
		bit        cur_valid;
		bit        cur_fifo;
		int        slice;
		int        in_flight;
		out_item_t pending[$];
		int        errors;
		int        n_done;
		int        n_reject;
		int        n_checked;

		function void clear();
			quantum = QuantumReset;
			now = 0;
			rr_q.delete();
			fifo_q.delete();
			cur = '0;
			cur_valid = 0;
			cur_fifo = 0;
			slice = 0;
			in_flight = 0;
			pending.delete();
		endfunction

		function void note_input(in_item_t it);
			out_item_t r;
			job_t j;
			int q;
			q = (quantum == 0) ? 1 : quantum;
			if (it.kind == KIND_ARRIVAL) begin
				if (it.service_time == 0 || in_flight >= Depth) begin
					r.status = ST_REJECT;
					r.done_id = it.job_id;
					r.done_priority = it.job_priority;
					r.done_service = it.service_time;
					r.turnaround = '0;
					r.finished_in = SRC_RR;
					pending.push_back(r);
					n_reject++;
					return;
				end
				j.id = it.job_id;
				j.prio = it.job_priority;
				j.serv = it.service_time;
				j.rem = it.service_time;
				j.arrival = now;
				rr_q.push_back(j);
				in_flight++;
				return;
			end
			now++;
			if (!cur_valid) begin
				if (rr_q.size() > 0) begin
					cur = rr_q.pop_front();
					cur_fifo = 0;
				end else if (fifo_q.size() > 0) begin
					cur = fifo_q.pop_front();
					cur_fifo = 1;
				end else begin
					return;
				end
				cur_valid = 1;
				slice = 0;
			end
			if (cur.rem > 0) cur.rem--;
			if (slice < 255) slice++;
			if (cur.rem == 0) begin
				r.status = ST_DONE;
				r.done_id = cur.id;
				r.done_priority = cur.prio;
				r.done_service = cur.serv;
				r.turnaround = now - cur.arrival;
				r.finished_in = cur_fifo ? SRC_FIFO : SRC_RR;
				pending.push_back(r);
				cur_valid = 0;
				if (in_flight > 0) in_flight--;
				n_done++;
				return;
			end
			if ((!cur_fifo && slice >= q) || (cur_fifo && rr_q.size() > 0)) begin
				fifo_q.push_back(cur);
				cur_valid = 0;
			end
		endfunction

		task automatic report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task automatic check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				report("unexpected result id", 32'(got.done_id), 32'd0);
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (got.status !== e.status)
				report("status", 32'(got.status), 32'(e.status));
			if (got.done_id !== e.done_id)
				report("done_id", 32'(got.done_id), 32'(e.done_id));
			if (got.done_priority !== e.done_priority)
				report("done_priority", 32'(got.done_priority), 32'(e.done_priority));
			if (got.done_service !== e.done_service)
				report("done_service", 32'(got.done_service), 32'(e.done_service));
			if (got.turnaround !== e.turnaround)
				report("turnaround", got.turnaround, e.turnaround);
			if (got.finished_in !== e.finished_in)
				report("finished_in", 32'(got.finished_in), 32'(e.finished_in));
		endtask
	endclass

endpackage

>>> dv/tb_top.sv
module tb_top;
	import tlfs_pkg::*;
	import tlfs_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;

	tlfs_in_if  in_ch();
	tlfs_out_if out_ch();
	tlfs_cfg_if cfg_ch();

	two_level_feedback_scheduler u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (in_ch.sink),
		.out   (out_ch.source),
		.cfg   (cfg_ch.sink)
	);

	sched_scoreboard sb;
	int n_items = 0;

	always #5 clk = ~clk;

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// starts and ends at a falling edge; valid stays high when no gap follows
	task automatic send_item(kind_t k, logic [15:0] id, logic [7:0] pr, logic [15:0] sv,
			bit no_gap = 0);
		int g;
		in_item_t it;
		it.kind = k;
		it.job_id = id;
		it.job_priority = pr;
		it.service_time = sv;
		in_ch.data <= it;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(it);
		n_items++;
		@(negedge clk);
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic tick();
		send_item(KIND_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
	endtask

	task automatic arrive(logic [15:0] sv);
		send_item(KIND_ARRIVAL, 16'($urandom), 8'($urandom), sv);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
	endtask

	task automatic write_quantum(logic [7:0] q);
		drain();
		cfg_ch.data <= q;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.quantum = q;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// run off queued work with ticks
	task automatic flush_jobs();
		while (sb.in_flight > 0) tick();
	endtask

	// result side
	initial begin
		int g;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int r;
		int sv;
		logic [7:0] qs[4];
		sb = new();
		sb.clear();
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: idle tick, zero service, extremes, demotion, preemption finish
		tick();
		arrive(16'd0);
		send_item(KIND_ARRIVAL, 16'hffff, 8'hff, 16'd1);
		send_item(KIND_ARRIVAL, 16'h0000, 8'h00, 16'd3);
		tick();
		tick();
		tick();
		tick();
		write_quantum(8'd1);
		arrive(16'd3);
		arrive(16'd2);
		tick();
		arrive(16'd1);
		repeat (6) tick();
		write_quantum(8'd0);
		arrive(16'd2);
		repeat (3) tick();
		flush_jobs();
		// fill to capacity then reject, the last one with the largest service
		write_quantum(8'd255);
		for (int i = 0; i < Depth + 1; i++)
			send_item(KIND_ARRIVAL, 16'(i), 8'(i), 16'd1, 1);
		send_item(KIND_ARRIVAL, 16'hffff, 8'hff, 16'hffff, 1);
		flush_jobs();
		tick();
		drain();
		write_quantum(8'd2);
		arrive(16'd5);
		arrive(16'd4);
		repeat (3) tick();
		flush_jobs();

		qs[0] = 8'd1; qs[1] = 8'd255; qs[2] = 8'd20; qs[3] = 8'd5;
		for (int ph = 0; ph < 4; ph++) begin
			write_quantum(qs[ph]);
			for (int i = 0; i < 220; i++) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					sv = $urandom_range(0, 99) < 90 ? $urandom_range(1, 8) :
						($urandom_range(0, 3) == 0 ? 0 : $urandom_range(9, 40));
					send_item(KIND_ARRIVAL, 16'($urandom), 8'($urandom), 16'(sv));
				end else begin
					tick();
				end
				if (i == 110 && ph == 1) drain();
			end
			flush_jobs();
		end
		drain();
		$display("covered %0d items: %0d completions, %0d rejections checked",
			n_items, sb.n_done, sb.n_reject);
		$display("quantum settings 0, 1, 2, 5, 20, 255 with random stalls on both channels");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
